// ----- sv/pdec_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Percent escape decoder package
// Shared transaction types and the percent byte code for the percent escape decoder.
// ----------------------------------------------------------------------------
package pdec_pkg;

   localparam logic [7:0] CHAR_PERCENT = 8'h25;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_text;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
   } rsp_type;

   // One queue entry holds the one or two bytes that one input transaction yields.
   typedef struct packed {
      logic [7:0] byte0;
      logic [7:0] byte1;
      logic       pair;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } push_type;

endpackage

// ----- sv/pdec_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Percent escape decoder front end
// Accepts input bytes, tracks escape and digit state, and forms the decoded
// bytes of each transaction as one queue entry.
// ----------------------------------------------------------------------------
module pdec_front
   import pdec_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  req_type  req_data,
   input  logic     queue_ready,
   output push_type push
);

   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_0     = 8'h30;
   localparam logic [7:0] CHAR_9     = 8'h39;
   localparam logic [7:0] CHAR_LA    = 8'h61;
   localparam logic [7:0] CHAR_LF    = 8'h66;
   localparam logic [7:0] CHAR_UA    = 8'h41;
   localparam logic [7:0] CHAR_UF    = 8'h46;

   function automatic logic is_space(input logic [7:0] c);
      return (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
   endfunction

   // Returns a found flag above the four-bit digit value.
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [4:0] r;
      r = '0;
      if (c >= CHAR_0 && c <= CHAR_9) begin
         r = {1'b1, c[3:0]};
      end else if ((c >= CHAR_LA && c <= CHAR_LF) || (c >= CHAR_UA && c <= CHAR_UF)) begin
         r = {1'b1, c[3:0] + 4'd9};
      end
      return r;
   endfunction

   // Base-16 parse of one or two digits or sign and digit; low eight bits kept.
   function automatic logic [7:0] convert(input logic two, input logic [7:0] d0,
                                          input logic [7:0] d1);
      logic [4:0] h0;
      logic [4:0] h1;
      logic [7:0] v1;
      logic [7:0] r;
      h0 = hex_digit(d0);
      h1 = hex_digit(d1);
      v1 = h1[4] ? {4'd0, h1[3:0]} : 8'd0;
      r  = 8'd0;
      if (!two) begin
         r = h0[4] ? {4'd0, h0[3:0]} : 8'd0;
      end else if (is_space(d0)) begin
         r = v1;
      end else if (d0 == CHAR_PLUS) begin
         r = v1;
      end else if (d0 == CHAR_MINUS) begin
         r = 8'd0 - v1;
      end else if (h0[4]) begin
         r = h1[4] ? {h0[3:0], h1[3:0]} : {4'd0, h0[3:0]};
      end
      return r;
   endfunction

   logic       escape_open_ff;
   logic       escape_open_in;
   logic [1:0] digit_count_ff;
   logic [1:0] digit_count_in;
   logic [7:0] digit_store_ff [2];
   logic [7:0] digit_store_in [2];
   logic       string_start_ff;
   logic       string_start_in;

   logic       accept;
   logic [7:0] c;
   logic       last;
   logic [1:0] n;
   logic [7:0] r0;
   logic [7:0] r1;

   assign req_ready = queue_ready;
   assign accept    = req_valid && req_ready;
   assign c         = req_data.in_byte;
   assign last      = req_data.end_of_text;

   always_comb begin
      escape_open_in    = escape_open_ff;
      digit_count_in    = digit_count_ff;
      digit_store_in[0] = digit_store_ff[0];
      digit_store_in[1] = digit_store_ff[1];
      n  = 2'd0;
      r0 = c;
      r1 = c;
      priority if (string_start_ff && last) begin
         n  = 2'd1;
         r0 = c;
      end else if (!escape_open_ff && c == CHAR_PERCENT) begin
         escape_open_in = 1'b1;
      end else if (escape_open_ff && digit_count_ff == 2'd0 && c == CHAR_PERCENT) begin
         escape_open_in = 1'b0;
         n  = 2'd1;
         r0 = CHAR_PERCENT;
      end else if (escape_open_ff && digit_count_ff < 2'd2) begin
         digit_store_in[digit_count_ff[0]] = c;
         digit_count_in = digit_count_ff + 2'd1;
         if (last) begin
            n  = 2'd1;
            r0 = convert(digit_count_in[1], digit_store_in[0], digit_store_in[1]);
         end
      end else begin
         escape_open_in = 1'b0;
         if (digit_count_ff != 2'd0) begin
            digit_count_in = 2'd0;
            r0 = convert(1'b1, digit_store_ff[0], digit_store_ff[1]);
            if (c == CHAR_PERCENT) begin
               escape_open_in = 1'b1;
               n = 2'd1;
            end else begin
               n  = 2'd2;
               r1 = c;
            end
         end else if (c == CHAR_PERCENT) begin
            escape_open_in = 1'b1;
         end else begin
            n  = 2'd1;
            r0 = c;
         end
      end
      if (last) begin
         escape_open_in  = 1'b0;
         digit_count_in  = 2'd0;
         string_start_in = 1'b1;
      end else begin
         string_start_in = 1'b0;
      end
   end

   assign push.valid       = accept && (n != 2'd0);
   assign push.entry.byte0 = r0;
   assign push.entry.byte1 = r1;
   assign push.entry.pair  = n[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         escape_open_ff  <= 1'b0;
         digit_count_ff  <= 2'd0;
         string_start_ff <= 1'b1;
      end else if (accept) begin
         escape_open_ff  <= escape_open_in;
         digit_count_ff  <= digit_count_in;
         string_start_ff <= string_start_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         digit_store_ff[0] <= digit_store_in[0];
         digit_store_ff[1] <= digit_store_in[1];
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      digit_count_ff != 2'd3)
      else $error("digit count out of range");

   a_digits_need_escape: assert property (@(posedge clock) disable iff (reset)
      !escape_open_ff |-> digit_count_ff == 2'd0)
      else $error("digits held with no escape open");

   a_last_restarts: assert property (@(posedge clock) disable iff (reset)
      accept && last |=> string_start_ff && !escape_open_ff)
      else $error("string state not cleared after last byte");

endmodule

// ----- sv/pdec_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Percent escape decoder queue
// Two-entry queue between the front end and the output stage; the head is
// always the first slot.
// ----------------------------------------------------------------------------
module pdec_queue
   import pdec_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  push_type  push,
   output logic      push_ready,
   input  logic      pop,
   output logic      head_valid,
   output entry_type head
);

   logic [1:0] count_ff;
   logic [1:0] count_in;
   entry_type  slot_ff [2];
   entry_type  slot_in [2];

   assign push_ready = count_ff != 2'd2;
   assign head_valid = count_ff != 2'd0;
   assign head       = slot_ff[0];

   always_comb begin
      count_in   = count_ff;
      slot_in[0] = slot_ff[0];
      slot_in[1] = slot_ff[1];
      unique case ({push.valid, pop})
         2'b11: begin
            if (count_ff == 2'd1) begin
               slot_in[0] = push.entry;
            end else begin
               slot_in[0] = slot_ff[1];
               slot_in[1] = push.entry;
            end
         end
         2'b01: begin
            slot_in[0] = slot_ff[1];
            count_in   = count_ff - 2'd1;
         end
         2'b10: begin
            if (count_ff == 2'd0) begin
               slot_in[0] = push.entry;
            end else begin
               slot_in[1] = push.entry;
            end
            count_in = count_ff + 2'd1;
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff[0] <= slot_in[0];
      slot_ff[1] <= slot_in[1];
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push.valid && count_ff == 2'd2))
      else $error("push into a full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && count_ff == 2'd0))
      else $error("pop from an empty queue");

endmodule

// ----- sv/pdec_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Percent escape decoder output stage
// Sends the one or two bytes of the queue head, one transaction per cycle while rsp_ready is high.
// ----------------------------------------------------------------------------
module pdec_back
   import pdec_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      head_valid,
   input  entry_type head,
   output logic      pop,
   output logic      rsp_valid,
   input  logic      rsp_ready,
   output rsp_type   rsp_data
);

   logic second_ff;
   logic second_in;
   logic send;

   assign rsp_valid         = head_valid;
   assign rsp_data.out_byte = second_ff ? head.byte1 : head.byte0;
   assign rsp_data.run_last = second_ff || !head.pair;
   assign send              = rsp_valid && rsp_ready;
   assign pop               = send && rsp_data.run_last;
   assign second_in         = send ? !rsp_data.run_last : second_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         second_ff <= 1'b0;
      end else begin
         second_ff <= second_in;
      end
   end

   a_second_needs_pair: assert property (@(posedge clock) disable iff (reset)
      second_ff |-> head_valid && head.pair)
      else $error("second byte selected without a pair at the head");

endmodule

// ----- sv/percent_escape_decoder_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Percent escape decoder
// Decodes percent-escaped strings, one byte per transaction, into zero, one or
// two decoded bytes per input byte.
//
//   Channel  Direction  Payload                      Handshake
//   req      in         in_byte, end_of_text         req_valid / req_ready
//   rsp      out        out_byte, run_last           rsp_valid / rsp_ready
//
// One input transaction is accepted per cycle while the two-entry queue has room.
// The output stage sends one byte per cycle while rsp_ready is high, so an input byte
// that yields two bytes is sent as two output transactions; bytes that yield nothing send none.
// Decoded bytes are registered in the queue slots before they reach the output.
// Reset is synchronous; there is no clearing pass.
// A stall on the output fills the queue and then lowers req_ready.
// ----------------------------------------------------------------------------
module percent_escape_decoder_top
   import pdec_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   push_type  push;
   logic      push_ready;
   logic      pop;
   logic      head_valid;
   entry_type head;

   pdec_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .queue_ready (push_ready),
      .push        (push)
   );

   pdec_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_ready (push_ready),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head)
   );

   pdec_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule
